// ----- src/psu_pkg.sv -----
// shared constants, codes and types of the png scanline unfilter
package psu_pkg;

   localparam int DEF_MAX_WIDTH = 1024;
   localparam int DEF_BPP       = 3;
   localparam int BYTE_W        = 8;
   localparam int WIDTH_W       = 11;
   localparam int CHAN_W        = 2;
   localparam int OUT_DEPTH     = 3;
   localparam int OUT_PTR_W     = 2;
   localparam int OUT_CNT_W     = 2;

   // filter codes of a row, bad marks a type above paeth
   typedef enum logic [2:0] {
      FILT_NONE  = 3'd0,
      FILT_SUB   = 3'd1,
      FILT_UP    = 3'd2,
      FILT_AVG   = 3'd3,
      FILT_PAETH = 3'd4,
      FILT_BAD   = 3'd5
   } psu_filt_type;

   // per sample control handed from row control to reconstruction
   typedef struct packed {
      logic [BYTE_W-1:0] data;
      psu_filt_type      filter;
      logic              first_row;
      logic              first_pixel;
      logic              last;
   } psu_item_type;

   typedef struct packed {
      logic [BYTE_W-1:0] pixel_byte;
      logic [CHAN_W-1:0] channel;
      logic              row_last;
      logic              bad_filter;
   } psu_rsp_type;

endpackage

// ----- src/psu_if.sv -----
// request, response and register write channels
interface psu_req_if;
   import psu_pkg::*;
   logic              valid;
   logic              ready;
   logic [BYTE_W-1:0] data_byte;
   logic              image_start;
   modport source (output valid, data_byte, image_start, input ready);
   modport sink (input valid, data_byte, image_start, output ready);
endinterface

interface psu_rsp_if;
   import psu_pkg::*;
   logic              valid;
   logic              ready;
   logic [BYTE_W-1:0] pixel_byte;
   logic [CHAN_W-1:0] channel;
   logic              row_last;
   logic              bad_filter;
   modport source (output valid, pixel_byte, channel, row_last, bad_filter, input ready);
   modport sink (input valid, pixel_byte, channel, row_last, bad_filter, output ready);
endinterface

interface psu_csr_if;
   import psu_pkg::*;
   logic               valid;
   logic               ready;
   logic [WIDTH_W-1:0] image_width;
   modport source (output valid, image_width, input ready);
   modport sink (input valid, image_width, output ready);
endinterface

// ----- src/psu_row_ctrl.sv -----
// row position tracking: filter byte capture, byte column and channel counters
module psu_row_ctrl import psu_pkg::*; #(
   parameter int MAX_WIDTH = DEF_MAX_WIDTH,
   parameter int BPP       = DEF_BPP,
   localparam int LINE_BYTES = MAX_WIDTH * BPP,
   localparam int COL_W = (LINE_BYTES > 1) ? $clog2(LINE_BYTES) : 1,
   localparam int CH_W  = (BPP > 1) ? $clog2(BPP) : 1
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               accept_i,
   input  logic [BYTE_W-1:0]  data_byte_i,
   input  logic               image_start_i,
   input  logic [WIDTH_W-1:0] image_width_i,
   output logic               issue_o,
   output logic [COL_W-1:0]   col_o,
   output logic [CH_W-1:0]    ch_o,
   output psu_item_type       item_o
);

   localparam int LEN_W = $clog2(LINE_BYTES + 1);

   logic [COL_W-1:0] col_ff, col_in;
   logic [CH_W-1:0]  ch_ff, ch_in;
   psu_filt_type     filter_ff, filter_in;
   logic             awaiting_ff, awaiting_in;
   logic             first_row_ff, first_row_in;

   logic             awaiting_now;
   logic [31:0]      width_wide;
   logic [LEN_W-1:0] width_eff;
   logic [LEN_W-1:0] row_len;
   logic [LEN_W-1:0] col_next;
   logic             last;

   // width clamped to 1..MAX_WIDTH
   always_comb begin
      width_wide = 32'(image_width_i);
      if (width_wide == 32'd0) begin
         width_eff = LEN_W'(1);
      end else if (width_wide > 32'(MAX_WIDTH)) begin
         width_eff = LEN_W'(MAX_WIDTH);
      end else begin
         width_eff = LEN_W'(width_wide);
      end
   end

   assign row_len      = LEN_W'(width_eff * LEN_W'(BPP));
   assign col_next     = LEN_W'(col_ff) + LEN_W'(1);
   assign last         = (col_next >= row_len);
   assign awaiting_now = awaiting_ff | image_start_i;
   assign issue_o      = accept_i & ~awaiting_now;
   assign col_o        = col_ff;
   assign ch_o         = ch_ff;

   always_comb begin
      item_o.data        = data_byte_i;
      item_o.filter      = filter_ff;
      item_o.first_row   = first_row_ff;
      item_o.first_pixel = (LEN_W'(col_ff) < LEN_W'(BPP));
      item_o.last        = last;
   end

   always_comb begin
      col_in       = col_ff;
      ch_in        = ch_ff;
      filter_in    = filter_ff;
      awaiting_in  = awaiting_ff;
      first_row_in = first_row_ff;
      if (accept_i) begin
         if (awaiting_now) begin
            // filter byte of a row
            if (data_byte_i > BYTE_W'(FILT_PAETH)) begin
               filter_in = FILT_BAD;
            end else begin
               filter_in = psu_filt_type'(data_byte_i[2:0]);
            end
            col_in      = '0;
            ch_in       = '0;
            awaiting_in = 1'b0;
            if (image_start_i) begin
               first_row_in = 1'b1;
            end
         end else if (last) begin
            col_in       = '0;
            ch_in        = '0;
            awaiting_in  = 1'b1;
            first_row_in = 1'b0;
         end else begin
            col_in = COL_W'(col_next);
            ch_in  = (ch_ff == CH_W'(BPP - 1)) ? '0 : ch_ff + CH_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff       <= '0;
         ch_ff        <= '0;
         filter_ff    <= FILT_NONE;
         awaiting_ff  <= 1'b1;
         first_row_ff <= 1'b1;
      end else begin
         col_ff       <= col_in;
         ch_ff        <= ch_in;
         filter_ff    <= filter_in;
         awaiting_ff  <= awaiting_in;
         first_row_ff <= first_row_in;
      end
   end

   a_last_rearms: assert property (@(posedge clock) disable iff (reset)
      (issue_o && last) |=> (awaiting_ff && col_ff == '0))
      else $error("row end did not rearm filter byte capture");

endmodule

// ----- src/psu_line_buf.sv -----
// previous row line buffer, one write and one registered read port
module psu_line_buf import psu_pkg::*; #(
   parameter int MAX_WIDTH = DEF_MAX_WIDTH,
   parameter int BPP       = DEF_BPP,
   localparam int LINE_BYTES = MAX_WIDTH * BPP,
   localparam int COL_W = (LINE_BYTES > 1) ? $clog2(LINE_BYTES) : 1
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              rd_en_i,
   input  logic [COL_W-1:0]  rd_addr_i,
   output logic [BYTE_W-1:0] rd_data_o,
   input  logic              wr_en_i,
   input  logic [COL_W-1:0]  wr_addr_i,
   input  logic [BYTE_W-1:0] wr_data_i
);

   logic [BYTE_W-1:0] line_mem_ff [LINE_BYTES];
   logic [BYTE_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en_i) begin
         line_mem_ff[wr_addr_i] <= wr_data_i;
      end
      if (rd_en_i) begin
         rd_data_ff <= line_mem_ff[rd_addr_i];
      end
   end

   assign rd_data_o = rd_data_ff;

   // a filter byte always separates a write from the next read of that column
   a_no_collision: assert property (@(posedge clock) disable iff (reset)
      (rd_en_i && wr_en_i) |-> (rd_addr_i != wr_addr_i))
      else $error("line buffer read and write hit the same column");

endmodule

// ----- src/psu_recon.sv -----
// reconstruction stage: predictor, left and upper-left registers, write back
module psu_recon import psu_pkg::*; #(
   parameter int MAX_WIDTH = DEF_MAX_WIDTH,
   parameter int BPP       = DEF_BPP,
   localparam int LINE_BYTES = MAX_WIDTH * BPP,
   localparam int COL_W = (LINE_BYTES > 1) ? $clog2(LINE_BYTES) : 1,
   localparam int CH_W  = (BPP > 1) ? $clog2(BPP) : 1
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              issue_i,
   input  logic [COL_W-1:0]  col_i,
   input  logic [CH_W-1:0]   ch_i,
   input  psu_item_type      item_i,
   input  logic [BYTE_W-1:0] upper_i,
   output logic              busy_o,
   output logic              wr_en_o,
   output logic [COL_W-1:0]  wr_addr_o,
   output logic [BYTE_W-1:0] wr_data_o,
   output logic              push_o,
   output psu_rsp_type       rsp_o
);

   logic              valid_ff;
   psu_item_type      item_ff;
   logic [COL_W-1:0]  col_ff;
   logic [CH_W-1:0]   ch_ff;
   logic [BYTE_W-1:0] left_ff [BPP];
   logic [BYTE_W-1:0] upleft_ff [BPP];

   logic [BYTE_W-1:0] a, b, c, pred, val;
   logic [BYTE_W:0]   avg_sum;
   logic signed [10:0] sa, sb, sc, p, pa, pb, pc;

   always_comb begin
      b = item_ff.first_row ? '0 : upper_i;
      a = item_ff.first_pixel ? '0 : left_ff[ch_ff];
      c = (item_ff.first_pixel || item_ff.first_row) ? '0 : upleft_ff[ch_ff];
   end

   // paeth distances
   always_comb begin
      sa = $signed({3'b000, a});
      sb = $signed({3'b000, b});
      sc = $signed({3'b000, c});
      p  = sa + sb - sc;
      pa = p - sa;
      pb = p - sb;
      pc = p - sc;
      if (pa < 0) begin
         pa = -pa;
      end
      if (pb < 0) begin
         pb = -pb;
      end
      if (pc < 0) begin
         pc = -pc;
      end
   end

   assign avg_sum = {1'b0, a} + {1'b0, b};

   always_comb begin
      unique case (item_ff.filter)
         FILT_SUB:   pred = a;
         FILT_UP:    pred = b;
         FILT_AVG:   pred = avg_sum[BYTE_W:1];
         FILT_PAETH: begin
            if (pa <= pb && pa <= pc) begin
               pred = a;
            end else if (pb <= pc) begin
               pred = b;
            end else begin
               pred = c;
            end
         end
         default:    pred = '0;
      endcase
   end

   assign val = item_ff.data + pred;

   assign busy_o    = valid_ff;
   assign wr_en_o   = valid_ff;
   assign wr_addr_o = col_ff;
   assign wr_data_o = val;
   assign push_o    = valid_ff;

   always_comb begin
      rsp_o.pixel_byte = val;
      rsp_o.channel    = CHAN_W'(ch_ff);
      rsp_o.row_last   = item_ff.last;
      rsp_o.bad_filter = (item_ff.filter == FILT_BAD);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= issue_i;
      end
   end

   always_ff @(posedge clock) begin
      if (issue_i) begin
         item_ff <= item_i;
         col_ff  <= col_i;
         ch_ff   <= ch_i;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < BPP; i++) begin
            left_ff[i]   <= '0;
            upleft_ff[i] <= '0;
         end
      end else if (valid_ff) begin
         left_ff[ch_ff]   <= val;
         upleft_ff[ch_ff] <= b;
      end
   end

endmodule

// ----- src/psu_out_fifo.sv -----
// three entry response queue between reconstruction and the response channel
module psu_out_fifo import psu_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push_i,
   input  psu_rsp_type          data_i,
   output logic [OUT_CNT_W-1:0] count_o,
   psu_rsp_if.source            rsp
);

   psu_rsp_type          entry_ff [OUT_DEPTH];
   logic [OUT_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [OUT_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [OUT_CNT_W-1:0] count_ff, count_in;
   logic                 pop;
   psu_rsp_type          head;

   function automatic logic [OUT_PTR_W-1:0] wrap_inc(input logic [OUT_PTR_W-1:0] ptr);
      return (ptr == OUT_PTR_W'(OUT_DEPTH - 1)) ? '0 : ptr + OUT_PTR_W'(1);
   endfunction

   assign head           = entry_ff[rd_ptr_ff];
   assign rsp.valid      = (count_ff != '0);
   assign rsp.pixel_byte = head.pixel_byte;
   assign rsp.channel    = head.channel;
   assign rsp.row_last   = head.row_last;
   assign rsp.bad_filter = head.bad_filter;
   assign pop            = rsp.valid & rsp.ready;
   assign count_o        = count_ff;

   always_comb begin
      wr_ptr_in = push_i ? wrap_inc(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = pop ? wrap_inc(rd_ptr_ff) : rd_ptr_ff;
      count_in  = count_ff;
      if (push_i && !pop) begin
         count_in = count_ff + OUT_CNT_W'(1);
      end else if (pop && !push_i) begin
         count_in = count_ff - OUT_CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_i) begin
         entry_ff[wr_ptr_ff] <= data_i;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push_i |-> (count_ff != OUT_CNT_W'(OUT_DEPTH) || pop))
      else $error("response queue overflow");

endmodule

// ----- src/png_scanline_unfilter_rgb8.sv -----
// top level of the png scanline unfilter for 8-bit rgb
//
// usage
//   req_chan carries the inflated stream one byte per request: at each row start
//   a filter type byte, then image_width*3 filtered samples. image_start marks
//   the first filter byte of an image. rsp_chan gives one reconstructed sample
//   per sample request with its channel, a row end flag and a bad filter flag;
//   filter bytes give no response. csr_chan writes image_width and is always
//   ready; write it only while no request is in flight.
// timing
//   one byte per cycle sustained while rsp_chan keeps up; an accepted sample
//   passes the reconstruction stage register and the response queue to rsp_chan.
//   the rate is set by the reconstruction stage, where the left neighbour of the
//   next pixel feeds back, and by the single write port of the line buffer.
// reset
//   control state is cleared and the next byte is taken as a filter byte of a
//   first row. the line buffer is not cleared: a first row never uses what it reads.
// stall
//   results queue in three entries; req_chan.ready drops only while the queue
//   and the reconstruction stage together hold three results.
module png_scanline_unfilter_rgb8 import psu_pkg::*; #(
   parameter int MAX_WIDTH = DEF_MAX_WIDTH,
   parameter int BPP       = DEF_BPP
) (
   input  logic      clock,
   input  logic      reset,
   psu_req_if.sink   req_chan,
   psu_rsp_if.source rsp_chan,
   psu_csr_if.sink   csr_chan
);

   localparam int LINE_BYTES = MAX_WIDTH * BPP;
   localparam int COL_W = (LINE_BYTES > 1) ? $clog2(LINE_BYTES) : 1;
   localparam int CH_W  = (BPP > 1) ? $clog2(BPP) : 1;

   // width register
   logic [WIDTH_W-1:0] width_ff, width_in;

   // request side
   logic accept;
   logic issue;
   logic [COL_W-1:0] issue_col;
   logic [CH_W-1:0]  issue_ch;
   psu_item_type     issue_item;

   // line buffer
   logic [BYTE_W-1:0] upper_byte;
   logic              wr_en;
   logic [COL_W-1:0]  wr_addr;
   logic [BYTE_W-1:0] wr_data;

   // response side
   logic                 stage_busy;
   logic                 push;
   psu_rsp_type          push_data;
   logic [OUT_CNT_W-1:0] queue_count;
   logic [OUT_CNT_W:0]   held;

   assign csr_chan.ready = 1'b1;
   assign width_in = (csr_chan.valid) ? csr_chan.image_width : width_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff <= WIDTH_W'(1);
      end else begin
         width_ff <= width_in;
      end
   end

   // credit: results in the queue plus the one in reconstruction
   assign held           = {1'b0, queue_count} + {{OUT_CNT_W{1'b0}}, stage_busy};
   assign req_chan.ready = (held < (OUT_CNT_W + 1)'(OUT_DEPTH));
   assign accept         = req_chan.valid & req_chan.ready;

   psu_row_ctrl #(
      .MAX_WIDTH (MAX_WIDTH),
      .BPP       (BPP)
   ) u_row_ctrl (
      .clock         (clock),
      .reset         (reset),
      .accept_i      (accept),
      .data_byte_i   (req_chan.data_byte),
      .image_start_i (req_chan.image_start),
      .image_width_i (width_ff),
      .issue_o       (issue),
      .col_o         (issue_col),
      .ch_o          (issue_ch),
      .item_o        (issue_item)
   );

   // upper byte is read as the sample enters and lands with the stage register
   psu_line_buf #(
      .MAX_WIDTH (MAX_WIDTH),
      .BPP       (BPP)
   ) u_line_buf (
      .clock     (clock),
      .reset     (reset),
      .rd_en_i   (issue),
      .rd_addr_i (issue_col),
      .rd_data_o (upper_byte),
      .wr_en_i   (wr_en),
      .wr_addr_i (wr_addr),
      .wr_data_i (wr_data)
   );

   psu_recon #(
      .MAX_WIDTH (MAX_WIDTH),
      .BPP       (BPP)
   ) u_recon (
      .clock     (clock),
      .reset     (reset),
      .issue_i   (issue),
      .col_i     (issue_col),
      .ch_i      (issue_ch),
      .item_i    (issue_item),
      .upper_i   (upper_byte),
      .busy_o    (stage_busy),
      .wr_en_o   (wr_en),
      .wr_addr_o (wr_addr),
      .wr_data_o (wr_data),
      .push_o    (push),
      .rsp_o     (push_data)
   );

   psu_out_fifo u_out_fifo (
      .clock   (clock),
      .reset   (reset),
      .push_i  (push),
      .data_i  (push_data),
      .count_o (queue_count),
      .rsp     (rsp_chan)
   );

   // issue needs an accepted request; a filter byte never reaches reconstruction
   a_filter_no_issue: assert property (@(posedge clock) disable iff (reset)
      !accept |-> !issue)
      else $error("sample issued without an accepted request");

   a_reset_quiet: assert property (@(posedge clock)
      $past(reset) |-> (!rsp_chan.valid && !stage_busy))
      else $error("response pending straight after reset");

endmodule

// ----- test/psu_unfilter_checker.sv -----
// checker of the png scanline unfilter: rebuilds every sample and compares responses
module psu_unfilter_checker import psu_pkg::*; (
   input  logic clock,
   input  logic reset,
   psu_req_if   req_mon,
   psu_rsp_if   rsp_mon,
   psu_csr_if   csr_mon,
   output int   outstanding,
   output int   fail_count
);

   localparam int LINE_LEN = DEF_MAX_WIDTH * DEF_BPP;

   logic [BYTE_W-1:0]  line_above [LINE_LEN];
   logic [BYTE_W-1:0]  left_px [DEF_BPP];
   logic [BYTE_W-1:0]  upleft_px [DEF_BPP];
   int                 col_pos;
   psu_filt_type       cur_filt;
   bit                 want_filter;
   bit                 top_row;
   logic [WIDTH_W-1:0] width_reg;
   psu_rsp_type        expected_pixels [$];
   int                 mismatches;

   initial begin
      mismatches = 0;
      for (int i = 0; i < LINE_LEN; i++) line_above[i] = '0;
   end

   function automatic logic [BYTE_W-1:0] paeth_choice(input logic [BYTE_W-1:0] a, b, c);
      int p, da, db, dc;
      p  = int'(a) + int'(b) - int'(c);
      da = p - int'(a);
      db = p - int'(b);
      dc = p - int'(c);
      if (da < 0) da = -da;
      if (db < 0) db = -db;
      if (dc < 0) dc = -dc;
      if (da <= db && da <= dc) return a;
      if (db <= dc) return b;
      return c;
   endfunction

   // filter bytes only set up the row, samples give one expected pixel byte
   task automatic rebuild_byte(input logic [BYTE_W-1:0] data, input logic start);
      int                eff_w, row_len, col, ch;
      logic [BYTE_W-1:0] a, b, c, pred, val;
      psu_rsp_type       exp_px;
      eff_w = (width_reg == 0) ? 1 : ((width_reg > DEF_MAX_WIDTH) ? DEF_MAX_WIDTH : width_reg);
      row_len = eff_w * DEF_BPP;
      if (start) begin
         top_row     = 1'b1;
         want_filter = 1'b1;
      end
      if (want_filter) begin
         cur_filt    = (data > 8'(FILT_PAETH)) ? FILT_BAD : psu_filt_type'(data[2:0]);
         col_pos     = 0;
         want_filter = 1'b0;
      end else begin
         col = (col_pos >= LINE_LEN) ? LINE_LEN - 1 : col_pos;
         ch  = col % DEF_BPP;
         b   = top_row ? '0 : line_above[col];
         a   = (col < DEF_BPP) ? '0 : left_px[ch];
         c   = (col < DEF_BPP || top_row) ? '0 : upleft_px[ch];
         case (cur_filt)
            FILT_SUB:   pred = a;
            FILT_UP:    pred = b;
            FILT_AVG:   pred = 8'((9'(a) + 9'(b)) >> 1);
            FILT_PAETH: pred = paeth_choice(a, b, c);
            default:    pred = '0;
         endcase
         val = data + pred;
         left_px[ch]     = val;
         upleft_px[ch]   = b;
         line_above[col] = val;
         exp_px.pixel_byte = val;
         exp_px.channel    = ch[CHAN_W-1:0];
         exp_px.row_last   = (col + 1 >= row_len);
         exp_px.bad_filter = (cur_filt == FILT_BAD);
         if (exp_px.row_last) begin
            want_filter = 1'b1;
            top_row     = 1'b0;
            col_pos     = 0;
         end else begin
            col_pos = col + 1;
         end
         expected_pixels.push_back(exp_px);
      end
   endtask

   task automatic check_pixel();
      psu_rsp_type exp_px;
      if (expected_pixels.size() == 0) begin
         if (mismatches < 10)
            $display("response with nothing expected: byte %02h chan %0d last %0b bad %0b",
                     rsp_mon.pixel_byte, rsp_mon.channel, rsp_mon.row_last,
                     rsp_mon.bad_filter);
         mismatches++;
      end else begin
         exp_px = expected_pixels.pop_front();
         if (rsp_mon.pixel_byte !== exp_px.pixel_byte || rsp_mon.channel !== exp_px.channel ||
             rsp_mon.row_last !== exp_px.row_last ||
             rsp_mon.bad_filter !== exp_px.bad_filter) begin
            if (mismatches < 10)
               $display("pixel mismatch: expected byte %02h chan %0d last %0b bad %0b, %s",
                        exp_px.pixel_byte, exp_px.channel, exp_px.row_last,
                        exp_px.bad_filter,
                        $sformatf("got byte %02h chan %0d last %0b bad %0b",
                                  rsp_mon.pixel_byte, rsp_mon.channel, rsp_mon.row_last,
                                  rsp_mon.bad_filter));
            mismatches++;
         end
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < DEF_BPP; i++) begin
            left_px[i]   = '0;
            upleft_px[i] = '0;
         end
         col_pos     = 0;
         cur_filt    = FILT_NONE;
         want_filter = 1'b1;
         top_row     = 1'b1;
         width_reg   = 11'd1;
         expected_pixels.delete();
      end else begin
         if (csr_mon.valid && csr_mon.ready) width_reg = csr_mon.image_width;
         if (req_mon.valid && req_mon.ready)
            rebuild_byte(req_mon.data_byte, req_mon.image_start);
         if (rsp_mon.valid && rsp_mon.ready) check_pixel();
      end
      outstanding <= expected_pixels.size();
      fail_count  <= mismatches;
   end

endmodule

// ----- test/tb_png_scanline_unfilter_rgb8.sv -----
// testbench top of the png scanline unfilter: stimulus, flow control and verdict
module tb_png_scanline_unfilter_rgb8;
   import psu_pkg::*;

   // longest stretch without any request, response or register write
   localparam int STALL_LIMIT = 2000;

   logic clock = 1'b0;
   logic reset;

   psu_req_if req_bus ();
   psu_rsp_if rsp_bus ();
   psu_csr_if csr_bus ();

   int outstanding;
   int fail_count;
   int quiet_cycles = 0;
   int bytes_sent   = 0;

   // idling modes of both sides and the one long hold-off of the receiver
   bit req_idle_on  = 1'b1;
   bit rsp_idle_on  = 1'b1;
   bit rsp_hold_due = 1'b0;

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   png_scanline_unfilter_rgb8 dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_bus),
      .rsp_chan (rsp_bus),
      .csr_chan (csr_bus)
   );

   psu_unfilter_checker u_check (
      .clock       (clock),
      .reset       (reset),
      .req_mon     (req_bus),
      .rsp_mon     (rsp_bus),
      .csr_mon     (csr_bus),
      .outstanding (outstanding),
      .fail_count  (fail_count)
   );

   // one request: optional gap with valid low, then hold it until taken
   task automatic push_byte(input logic [BYTE_W-1:0] data, input logic start);
      int gap;
      if ($urandom_range(0, 63) == 0) req_idle_on = !req_idle_on;
      gap = req_idle_on ? $urandom_range(0, 7) : 0;
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid       <= 1'b1;
      req_bus.data_byte   <= data;
      req_bus.image_start <= start;
      do @(posedge clock); while (!(req_bus.valid && req_bus.ready));
      bytes_sent++;
   endtask

   // samples lean towards the ends of the byte range now and then
   function automatic logic [BYTE_W-1:0] random_sample();
      case ($urandom_range(0, 7))
         0:       return 8'h00;
         1:       return 8'hff;
         default: return 8'($urandom);
      endcase
   endfunction

   // filter byte followed by count random samples
   task automatic send_row(input logic [BYTE_W-1:0] filt, input logic start, input int count);
      push_byte(filt, start);
      repeat (count) push_byte(random_sample(), 1'b0);
   endtask

   // stop sending, let every response drain, then give filter bytes time to pass
   task automatic settle();
      req_bus.valid <= 1'b0;
      do @(posedge clock); while (outstanding != 0);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_width(input logic [WIDTH_W-1:0] w);
      csr_bus.valid       <= 1'b1;
      csr_bus.image_width <= w;
      do @(posedge clock); while (!(csr_bus.valid && csr_bus.ready));
      csr_bus.valid <= 1'b0;
   endtask

   // receiver: random gaps per response, stretches without gaps, one long hold-off
   initial begin
      int gap;
      rsp_bus.ready <= 1'b0;
      do @(posedge clock); while (reset !== 1'b0);
      forever begin
         if ($urandom_range(0, 47) == 0) rsp_idle_on = !rsp_idle_on;
         gap = rsp_idle_on ? $urandom_range(0, 7) : 0;
         if (rsp_hold_due) begin
            // long enough for the result queue to fill and the input to stall
            gap          = 64;
            rsp_hold_due = 1'b0;
         end
         if (gap > 0) begin
            rsp_bus.ready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_bus.ready <= 1'b1;
         do @(posedge clock); while (!(rsp_bus.valid && rsp_bus.ready));
      end
   end

   // watchdog on cycles in which nothing at all is accepted
   always @(posedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready) ||
          (csr_bus.valid && csr_bus.ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
         $display("== FAIL ==");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      int         w, n, rows, random_base;
      logic [7:0] filt;
      bit         fresh;
      reset               <= 1'b1;
      req_bus.valid       <= 1'b0;
      req_bus.data_byte   <= '0;
      req_bus.image_start <= 1'b0;
      csr_bus.valid       <= 1'b0;
      csr_bus.image_width <= '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed part, two pixels per row
      write_width(11'd2);
      // average on a first row: no upper row and a zero left on the first pixel
      push_byte(8'(FILT_AVG), 1'b1);
      push_byte(8'hff, 1'b0);
      push_byte(8'h80, 1'b0);
      push_byte(8'h01, 1'b0);
      push_byte(8'h10, 1'b0);
      push_byte(8'h20, 1'b0);
      push_byte(8'h30, 1'b0);
      // paeth against the row above, wrapping modulo 256
      push_byte(8'(FILT_PAETH), 1'b0);
      push_byte(8'h00, 1'b0);
      push_byte(8'hff, 1'b0);
      push_byte(8'h07, 1'b0);
      push_byte(8'hc8, 1'b0);
      push_byte(8'h64, 1'b0);
      push_byte(8'h32, 1'b0);
      // highest filter value: rebuilt as none and flagged, then cut short
      push_byte(8'hff, 1'b0);
      push_byte(8'hff, 1'b0);
      push_byte(8'h00, 1'b0);
      push_byte(8'h5a, 1'b0);
      // new image in mid-row drops the row in progress
      push_byte(8'(FILT_UP), 1'b1);
      push_byte(8'h11, 1'b0);
      push_byte(8'h22, 1'b0);
      push_byte(8'h33, 1'b0);
      push_byte(8'h44, 1'b0);
      // width shrinks in mid-row, zero counts as one pixel: the next sample ends the row
      settle();
      write_width(11'd0);
      push_byte(8'h55, 1'b0);
      push_byte(8'(FILT_SUB), 1'b0);
      push_byte(8'h01, 1'b0);
      push_byte(8'h02, 1'b0);
      push_byte(8'h03, 1'b0);

      // random part: mostly whole images at narrow widths, some broken rows and bad types
      random_base = bytes_sent;
      while (bytes_sent - random_base < 900) begin
         n = $urandom_range(0, 15);
         w = (n < 10) ? $urandom_range(1, 4) : (n < 15) ? $urandom_range(5, 16) :
             $urandom_range(17, 40);
         // widths only change with a new image following, so no unwritten line entry is read
         settle();
         write_width(11'(w));
         if (random_base == bytes_sent) rsp_hold_due = 1'b1;
         repeat ($urandom_range(1, 3)) begin
            rows  = $urandom_range(1, 4);
            fresh = 1'b1;
            for (int i = 0; i < rows; i++) begin
               filt = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(5, 255)) :
                      8'($urandom_range(0, 4));
               n = w * DEF_BPP;
               // now and then a row is broken off and a new image begins
               if ($urandom_range(0, 15) == 0) n = $urandom_range(0, w * DEF_BPP - 1);
               send_row(filt, fresh, n);
               fresh = (n < w * DEF_BPP);
            end
         end
      end

      settle();
      repeat (4) @(posedge clock);
      if (fail_count == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule

// ----- filelist.f -----
src/psu_pkg.sv
src/psu_if.sv
src/psu_row_ctrl.sv
src/psu_line_buf.sv
src/psu_recon.sv
src/psu_out_fifo.sv
src/png_scanline_unfilter_rgb8.sv
test/psu_unfilter_checker.sv
test/tb_png_scanline_unfilter_rgb8.sv
